>>> rtl/core/integer_field_formatter_top_defines.svh
// ----------------------------------------------------------------------------
// integer_field_formatter_top_defines.svh
// Assertion macros for the integer field formatter.
// ----------------------------------------------------------------------------
`ifndef INTEGER_FIELD_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_TOP_DEFINES_SVH

// same-cycle implication
`define IFF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IFF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/iff_pkg.sv
// ----------------------------------------------------------------------------
// iff_pkg
// Shared types, constants and helpers of the integer field formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iff_pkg;

   localparam int VALUE_BITS  = 64;
   localparam int MAX_FIELD   = 63;
   localparam int DIGITS      = 20;
   localparam int LEN_BITS    = 5;
   localparam int CNT_BITS    = 7;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_LA    = 8'h61;

   typedef enum logic [1:0] {
      D_IDLE,
      D_CONV,
      D_SCAN,
      D_READY
   } iff_dig_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_PREP,
      ST_BOUND,
      ST_EMIT,
      ST_EMPTY
   } iff_state_type;

   typedef struct packed {
      logic load;
      logic hex;
      logic pop;
   } iff_dig_ctl_type;

   typedef struct packed {
      logic                ready;
      logic [LEN_BITS-1:0] len;
      logic [3:0]          top;
   } iff_dig_sts_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
      logic [7:0] base;
      base = lower ? CHAR_LA : CHAR_UA;
      if (d < 4'd10) digit_char = CHAR_ZERO + {4'd0, d};
      else           digit_char = base + {4'd0, d} - 8'd10;
   endfunction

endpackage

>>> rtl/core/iff_digits.sv
// ----------------------------------------------------------------------------
// iff_digits
// Bit-serial binary to BCD/hex digit converter with leading-zero scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iff_digits
   import iff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  iff_dig_ctl_type       ctl,
   input  logic [VALUE_BITS-1:0] magnitude,
   output iff_dig_sts_type       sts
);

   iff_dig_state_type       state_ff, state_in;
   logic [VALUE_BITS-1:0]   mag_ff, mag_in;
   logic [4*DIGITS-1:0]     digit_store_ff, digit_store_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [LEN_BITS-1:0]     len_ff, len_in;
   logic                    hex_ff, hex_in;
   logic [4*DIGITS-1:0]     adj;

   // add-3 correction on every digit before each shift (decimal only)
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (!hex_ff && digit_store_ff[4*i +: 4] >= 4'd5)
            adj[4*i +: 4] = digit_store_ff[4*i +: 4] + 4'd3;
         else
            adj[4*i +: 4] = digit_store_ff[4*i +: 4];
      end
   end

   always_comb begin
      state_in       = state_ff;
      mag_in         = mag_ff;
      digit_store_in = digit_store_ff;
      cnt_in         = cnt_ff;
      len_in         = len_ff;
      hex_in         = hex_ff;
      if (ctl.load) begin
         state_in       = D_CONV;
         mag_in         = magnitude;
         digit_store_in = '0;
         cnt_in         = '0;
         hex_in         = ctl.hex;
      end else begin
         unique case (state_ff)
            D_IDLE: ;
            D_CONV: begin
               digit_store_in = {adj[4*DIGITS-2:0], mag_ff[VALUE_BITS-1]};
               mag_in         = {mag_ff[VALUE_BITS-2:0], 1'b0};
               cnt_in         = cnt_ff + CNT_BITS'(1);
               if (cnt_ff == CNT_BITS'(VALUE_BITS - 1)) begin
                  state_in = D_SCAN;
                  len_in   = LEN_BITS'(DIGITS);
               end
            end
            D_SCAN: begin
               if (digit_store_ff[4*DIGITS-1 -: 4] == 4'd0 && len_ff > LEN_BITS'(1)) begin
                  digit_store_in = {digit_store_ff[4*DIGITS-5:0], 4'd0};
                  len_in         = len_ff - LEN_BITS'(1);
               end else begin
                  state_in = D_READY;
               end
            end
            D_READY: begin
               if (ctl.pop) digit_store_in = {digit_store_ff[4*DIGITS-5:0], 4'd0};
            end
            default: state_in = D_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= D_IDLE;
      else       state_ff <= state_in;
      mag_ff         <= mag_in;
      digit_store_ff <= digit_store_in;
      cnt_ff         <= cnt_in;
      len_ff         <= len_in;
      hex_ff         <= hex_in;
   end

   assign sts.ready = (state_ff == D_READY);
   assign sts.len   = len_ff;
   assign sts.top   = digit_store_ff[4*DIGITS-1 -: 4];

endmodule

>>> rtl/core/integer_field_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_field_formatter_top
// Formats one signed integer as a padded decimal or hex field, one char/cycle.
// ----------------------------------------------------------------------------
// Sequence: the digit converter shifts the magnitude in bit-serially and then
// scans off leading zeros; the ready, prep and bound states and the output
// register follow before the first character, then one character per cycle.
// Requests: busy holds from the accepting edge until the last character, so a
// new request waits for the previous one; an error request gives one empty result.
// Reset clears the control state; the receiver cannot stall results.
`timescale 1ns / 1ps
`include "integer_field_formatter_top_defines.svh"

module integer_field_formatter_top
   import iff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [63:0]           req_value,
   input  logic                  req_radix_hex,
   input  logic                  req_lower_hex,
   input  logic [6:0]            req_field_width,
   input  logic [6:0]            req_min_digits,
   input  logic                  req_precision_given,
   input  logic                  req_left_justify,
   input  logic                  req_zero_pad,
   input  logic                  req_error_in,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_char_out,
   output logic                  rsp_char_valid,
   output logic                  rsp_last_char,
   output logic [6:0]            rsp_total_length
);

   iff_state_type    state_ff, state_in;
   iff_dig_ctl_type  dctl;
   iff_dig_sts_type  dsts;
   logic [VALUE_BITS-1:0] mag;

   logic       neg_ff, lower_ff, pgiven_ff, left_ff, zero_ff, zmag_ff;
   logic [6:0] fw_ff, md_ff;
   logic [6:0] lead_ff, lead_in, zeros_ff, zeros_in, trail_ff, trail_in;
   logic [4:0] len_ff, len_in;
   logic       sign_ff, sign_in;
   logic [6:0] b_zero_ff, b_dig_ff, b_trail_ff, b_end_ff, b_sign_ff;
   logic [6:0] emit_counter_ff, emit_counter_in;

   logic       out_valid_ff, out_valid_in, out_cv_ff, out_cv_in, out_last_ff, out_last_in;
   logic [7:0] out_char_ff, out_char_in;
   logic [6:0] out_len_ff, out_len_in;

   // setup arithmetic
   logic       left_e, zero_e, special;
   logic [6:0] w_abs, w, prec, space, mx, pad, len_neg;

   assign mag = req_value[VALUE_BITS-1] ?
                (~req_value[VALUE_BITS-1:0] + VALUE_BITS'(1)) : req_value[VALUE_BITS-1:0];

   always_comb begin
      w_abs   = fw_ff[6] ? (~fw_ff + 7'd1) : fw_ff;
      w       = (w_abs > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : w_abs;
      left_e  = left_ff | fw_ff[6];
      special = pgiven_ff && (md_ff == 7'd0) && zmag_ff;
      prec    = md_ff[6] ? 7'd0 : md_ff;
      zero_e  = zero_ff & ~left_e & ~(pgiven_ff & ~md_ff[6]);
      mx      = (prec > {2'd0, dsts.len}) ? prec : {2'd0, dsts.len};
      space   = mx + {6'd0, neg_ff};
      pad     = (w > space) ? (w - space) : 7'd0;
      len_neg = {2'd0, dsts.len} + {6'd0, neg_ff};
      if (special) begin
         lead_in  = w;
         sign_in  = 1'b0;
         zeros_in = 7'd0;
         len_in   = 5'd0;
         trail_in = 7'd0;
      end else begin
         lead_in  = (!left_e && !zero_e) ? pad : 7'd0;
         sign_in  = neg_ff;
         if (zero_e) zeros_in = (w > len_neg) ? (w - len_neg) : 7'd0;
         else        zeros_in = (prec > {2'd0, dsts.len}) ? (prec - {2'd0, dsts.len}) : 7'd0;
         len_in   = dsts.len;
         trail_in = left_e ? pad : 7'd0;
      end
   end

   always_comb begin
      state_in        = state_ff;
      emit_counter_in = emit_counter_ff;
      dctl.load       = 1'b0;
      dctl.hex        = req_radix_hex;
      dctl.pop        = 1'b0;
      out_valid_in    = 1'b0;
      out_char_in     = 8'd0;
      out_cv_in       = 1'b0;
      out_last_in     = 1'b0;
      out_len_in      = 7'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_error_in) begin
                  state_in = ST_EMPTY;
               end else begin
                  state_in  = ST_CONV;
                  dctl.load = 1'b1;
               end
            end
         end
         ST_CONV:  if (dsts.ready) state_in = ST_PREP;
         ST_PREP:  state_in = ST_BOUND;
         ST_BOUND: begin
            emit_counter_in = 7'd0;
            // bounds are still loading this cycle: test the segment lengths
            state_in = ((lead_ff | zeros_ff | trail_ff) == 7'd0 && len_ff == 5'd0 &&
                        !sign_ff) ? ST_EMPTY : ST_EMIT;
         end
         ST_EMIT: begin
            out_valid_in = 1'b1;
            out_cv_in    = 1'b1;
            priority if (emit_counter_ff < b_sign_ff) out_char_in = CHAR_SPACE;
            else if (emit_counter_ff < b_zero_ff)     out_char_in = CHAR_MINUS;
            else if (emit_counter_ff < b_dig_ff)      out_char_in = CHAR_ZERO;
            else if (emit_counter_ff < b_trail_ff) begin
               out_char_in = digit_char(dsts.top, lower_ff);
               dctl.pop    = 1'b1;
            end else out_char_in = CHAR_SPACE;
            emit_counter_in = emit_counter_ff + 7'd1;
            if (emit_counter_in == b_end_ff) begin
               out_last_in = 1'b1;
               out_len_in  = b_end_ff;
               state_in    = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            out_valid_in = 1'b1;
            out_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         emit_counter_ff <= 7'd0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         emit_counter_ff <= emit_counter_in;
         out_valid_ff    <= out_valid_in;
      end
      out_char_ff <= out_char_in;
      out_cv_ff   <= out_cv_in;
      out_last_ff <= out_last_in;
      out_len_ff  <= out_len_in;
      if (state_ff == ST_IDLE) begin
         neg_ff    <= req_value[VALUE_BITS-1];
         lower_ff  <= req_lower_hex;
         pgiven_ff <= req_precision_given;
         left_ff   <= req_left_justify;
         zero_ff   <= req_zero_pad;
         zmag_ff   <= (req_value[VALUE_BITS-1:0] == '0);
         fw_ff     <= req_field_width;
         md_ff     <= req_min_digits;
      end
      if (state_ff == ST_PREP) begin
         lead_ff  <= lead_in;
         sign_ff  <= sign_in;
         zeros_ff <= zeros_in;
         len_ff   <= len_in;
         trail_ff <= trail_in;
      end
      if (state_ff == ST_BOUND || state_ff == ST_PREP) begin
         b_sign_ff  <= lead_ff;
         b_zero_ff  <= lead_ff + {6'd0, sign_ff};
         b_dig_ff   <= lead_ff + {6'd0, sign_ff} + zeros_ff;
         b_trail_ff <= lead_ff + {6'd0, sign_ff} + zeros_ff + {2'd0, len_ff};
         b_end_ff   <= lead_ff + {6'd0, sign_ff} + zeros_ff + {2'd0, len_ff} + trail_ff;
      end
   end

   iff_digits u_digits (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dctl),
      .magnitude (mag),
      .sts       (dsts)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = out_valid_ff;
   assign rsp_char_out     = out_char_ff;
   assign rsp_char_valid   = out_cv_ff;
   assign rsp_last_char    = out_last_ff;
   assign rsp_total_length = out_len_ff;

   `IFF_ASSERT_NOW(a_last_idle, rsp_valid && rsp_last_char, !busy, "busy after last result")
   `IFF_ASSERT_NOW(a_empty_last, rsp_valid && !rsp_char_valid, rsp_last_char, "empty not last")
   `IFF_ASSERT_NEXT(a_start_busy, start && !busy, busy, "transaction not taken")
   `IFF_ASSERT_NOW(a_len_last, rsp_valid && !rsp_last_char, rsp_total_length == 7'd0, "length on non-last result")

endmodule
